// ===== design/time_ordered_waypoint_table_defines.svh =====
// Assertion macros shared by the waypoint table design.
`ifndef TIME_ORDERED_WAYPOINT_TABLE_DEFINES_SVH
`define TIME_ORDERED_WAYPOINT_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TWT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define TWT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/twt_pkg.sv =====
// Package with the shared types and constants of the waypoint table.
`timescale 1ns / 1ps
package twt_pkg;

    // Default number of waypoint cells in the ring.
    localparam int TWT_DEPTH_DEFAULT = 64;

    // Width of the remaining-count field and its saturation value.
    localparam int REM_W   = 7;
    localparam int REM_MAX = 127;

    // Width of the read index field.
    localparam int IDX_W = 6;

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One stored waypoint.
    typedef struct packed {
        logic [31:0]        tstamp;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic signed [31:0] yaw;
    } entry_t;

    // Ring control from the sequencer to the cell chain.
    typedef struct packed {
        logic shift;
        logic inject;
    } ring_ctl_t;

endpackage

// ===== design/twt_cell.sv =====
// One cell of the waypoint ring: holds a single entry and passes it on.
`timescale 1ns / 1ps
module twt_cell
    import twt_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  entry_t d,
    output entry_t q
);

    entry_t entry_reg;

    // Take the neighbour's entry whenever the ring rotates.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

// ===== design/twt_ctrl.sv =====
// Sequencer of the waypoint table: rotates the ring once per word and forms the result.
`timescale 1ns / 1ps
module twt_ctrl
    import twt_pkg::*;
#(
    parameter int TABLE_DEPTH = TWT_DEPTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           op,
    input  logic [31:0]                          time_stamp,
    input  logic signed [31:0]                   pos_x,
    input  logic signed [31:0]                   pos_y,
    input  logic signed [31:0]                   pos_z,
    input  logic signed [31:0]                   pitch_in,
    input  logic signed [31:0]                   roll_in,
    input  logic signed [31:0]                   yaw_in,
    input  logic [IDX_W-1:0]                     entry_index,
    input  entry_t                               head,
    output ring_ctl_t                            ring,
    output entry_t                               new_entry,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 accepted,
    output logic                                 found,
    output logic [31:0]                          out_time,
    output logic signed [31:0]                   out_x,
    output logic signed [31:0]                   out_y,
    output logic signed [31:0]                   out_z,
    output logic signed [31:0]                   out_pitch,
    output logic signed [31:0]                   out_roll,
    output logic signed [31:0]                   out_yaw,
    output logic [REM_W-1:0]                     remaining
);

    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int RW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam int SATW = (CW > REM_W) ? CW : REM_W;

    state_t           state_reg, state_next;
    logic [RW-1:0]    r_reg;
    logic [CW-1:0]    count_reg;
    logic             ok_reg;
    logic             found_reg;
    logic             out_valid_reg;
    op_t              op_reg;
    logic [31:0]      time_reg;
    entry_t           new_reg;
    logic [IDX_W-1:0] idx_reg;
    entry_t           cap_reg;
    logic [CW-1:0]    qrem_reg;
    logic             accepted_reg;
    logic             found_out_reg;
    entry_t           out_entry_reg;
    logic [REM_W-1:0] remaining_reg;

    logic          in_accept;
    logic          out_take;
    logic          finish;
    logic [CW-1:0] r_cnt;
    logic          in_range;
    logic          is_tail;
    logic          late;
    logic          hit;
    logic          append_ok;
    logic [CW-1:0] rem_val;

    // Handshake terms.
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign finish    = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // Compare terms for the entry now at the head of the ring.
    assign r_cnt    = CW'(r_reg);
    assign in_range = r_cnt < count_reg;
    assign is_tail  = (count_reg != '0) && (r_cnt == count_reg - CW'(1));
    assign late     = head.tstamp > time_reg;
    assign hit      = (state_reg == ST_SCAN) && in_range &&
                      (((op_reg == OP_QUERY) && !found_reg && late) ||
                       ((op_reg == OP_READ) && (CMPW'(r_reg) == CMPW'(idx_reg))));
    assign append_ok = (op_reg == OP_APPEND) && ok_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (r_reg == RW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        ring.shift  = (state_reg == ST_SCAN);
        ring.inject = (state_reg == ST_SCAN) && append_ok && (r_cnt == count_reg);
    end

    // Remaining count before saturation.
    always_comb
    begin
        if (op_reg == OP_QUERY)
        begin
            rem_val = found_reg ? qrem_reg : '0;
        end
        else if (append_ok)
        begin
            rem_val = count_reg + CW'(1);
        end
        else
        begin
            rem_val = count_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            count_reg     <= '0;
            ok_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                r_reg     <= '0;
                ok_reg    <= (count_reg != CW'(TABLE_DEPTH));
                found_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (r_reg != RW'(TABLE_DEPTH - 1))
                begin
                    r_reg <= r_reg + RW'(1);
                end
                // An earlier arrival time than the tail entry rejects the append.
                if ((op_reg == OP_APPEND) && is_tail && late)
                begin
                    ok_reg <= 1'b0;
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (finish && append_ok)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Word capture, hit capture and result register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= op_t'(op);
            time_reg <= time_stamp;
            new_reg  <= '{tstamp: time_stamp, x: pos_x, y: pos_y, z: pos_z,
                          pitch: pitch_in, roll: roll_in, yaw: yaw_in};
            idx_reg  <= entry_index;
        end
        if (hit)
        begin
            cap_reg  <= head;
            qrem_reg <= count_reg - r_cnt;
        end
        if (finish)
        begin
            accepted_reg  <= append_ok;
            found_out_reg <= found_reg;
            out_entry_reg <= found_reg ? cap_reg : '0;
            remaining_reg <= (SATW'(rem_val) > SATW'(REM_MAX)) ? REM_W'(REM_MAX)
                                                              : REM_W'(rem_val);
        end
    end

    assign new_entry = new_reg;
    assign count     = count_reg;
    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign found     = found_out_reg;
    assign out_time  = out_entry_reg.tstamp;
    assign out_x     = out_entry_reg.x;
    assign out_y     = out_entry_reg.y;
    assign out_z     = out_entry_reg.z;
    assign out_pitch = out_entry_reg.pitch;
    assign out_roll  = out_entry_reg.roll;
    assign out_yaw   = out_entry_reg.yaw;
    assign remaining = remaining_reg;

endmodule

// ===== design/time_ordered_waypoint_table.sv =====
// Waypoint table holding entries in arrival order, top level.
//
// Input channel: in_valid / in_stall carry one word (op, time_stamp, position,
// angles, entry_index). Output channel: out_valid / out_stall carry one result
// word per input word (accepted, found, entry fields, remaining).
// The entries sit in a ring of TABLE_DEPTH cells. Every word rotates the ring
// exactly once, so the head cell shows entry 0, 1, 2, ... in turn; an append
// is dropped into the tail cell as its slot passes, a query or read captures
// the matching entry as it passes the head.
// The result is registered once the rotation and the finish state are through.
// A new word is taken only after the full rotation of the ring for the last
// word; in_stall is high for the whole rotation and the finish state.
// A result waiting on out_stall does not block the next word; only the end of
// that next rotation waits until the output register is free.
// Reset empties the table at once (count to zero, no clearing pass); the
// entry contents are only read below the count.
`timescale 1ns / 1ps
`include "time_ordered_waypoint_table_defines.svh"
module time_ordered_waypoint_table
    import twt_pkg::*;
#(
    parameter int TABLE_DEPTH = TWT_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [31:0]        time_stamp,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] pitch_in,
    input  logic signed [31:0] roll_in,
    input  logic signed [31:0] yaw_in,
    input  logic [IDX_W-1:0]   entry_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic               found,
    output logic [31:0]        out_time,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_pitch,
    output logic signed [31:0] out_roll,
    output logic signed [31:0] out_yaw,
    output logic [REM_W-1:0]   remaining
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    entry_t        cell_q [TABLE_DEPTH];
    entry_t        head;
    entry_t        new_entry;
    entry_t        tail_d;
    ring_ctl_t     ring;
    logic [CW-1:0] count;

    // The head entry returns to the tail unless an append fills that slot.
    assign head   = cell_q[0];
    assign tail_d = ring.inject ? new_entry : head;

    // Ring of cells, each handing its entry towards the head.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            twt_cell u_cell (
                .clk   (clk),
                .shift (ring.shift),
                .d     (tail_d),
                .q     (cell_q[i])
            );
        end
        else
        begin : g_body
            twt_cell u_cell (
                .clk   (clk),
                .shift (ring.shift),
                .d     (cell_q[i+1]),
                .q     (cell_q[i])
            );
        end
    end

    // Sequencer and result register.
    twt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .time_stamp  (time_stamp),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .pitch_in    (pitch_in),
        .roll_in     (roll_in),
        .yaw_in      (yaw_in),
        .entry_index (entry_index),
        .head        (head),
        .ring        (ring),
        .new_entry   (new_entry),
        .count       (count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .found       (found),
        .out_time    (out_time),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_pitch   (out_pitch),
        .out_roll    (out_roll),
        .out_yaw     (out_yaw),
        .remaining   (remaining)
    );

    // The table never holds more entries than it has cells.
    `TWT_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH), "entry count above depth")
    // An accepted word starts a rotation, so the input stalls next cycle.
    `TWT_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")
    // A stored append never reports a returned entry.
    `TWT_ASSERT_IMP(a_append_not_found, out_valid && accepted, !found, "append reported found")
    // Only a stored append can raise the entry count.
    `TWT_ASSERT_NXT(a_count_step, 1'b1, (count == $past(count)) || (count == $past(count) + CW'(1)),
                    "entry count changed by more than one")

endmodule

// ===== tb/sv/time_ordered_waypoint_table_tb.sv =====
// Self-checking testbench for the time-ordered waypoint table.
`timescale 1ns / 1ps
module time_ordered_waypoint_table_tb;
    import twt_pkg::*;

    localparam int TABLE_DEPTH = TWT_DEPTH_DEFAULT;
    localparam int RANDOM_WORDS = 1200;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 40;

    // One input word as the driver presents it.
    typedef struct {
        op_t                op;
        logic [31:0]        tstamp;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic signed [31:0] yaw;
        logic [IDX_W-1:0]   idx;
    } waypoint_word_t;

    // One result word as the table should return it.
    typedef struct {
        logic             accepted;
        logic             found;
        entry_t           entry;
        logic [REM_W-1:0] remaining;
    } waypoint_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          op = '0;
    logic [31:0]         time_stamp = '0;
    logic signed [31:0]  pos_x = '0;
    logic signed [31:0]  pos_y = '0;
    logic signed [31:0]  pos_z = '0;
    logic signed [31:0]  pitch_in = '0;
    logic signed [31:0]  roll_in = '0;
    logic signed [31:0]  yaw_in = '0;
    logic [IDX_W-1:0]    entry_index = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                accepted;
    logic                found;
    logic [31:0]         out_time;
    logic signed [31:0]  out_x;
    logic signed [31:0]  out_y;
    logic signed [31:0]  out_z;
    logic signed [31:0]  out_pitch;
    logic signed [31:0]  out_roll;
    logic signed [31:0]  out_yaw;
    logic [REM_W-1:0]    remaining;

    // Words waiting to be driven, and results waiting to arrive.
    waypoint_word_t   pending_words[$];
    waypoint_result_t expected_results[$];

    // Shadow of the table contents used for prediction.
    entry_t stored_entries[TABLE_DEPTH];
    int     stored_count = 0;

    // What the stimulus generator knows of the table while it builds words.
    logic [31:0] gen_times[TABLE_DEPTH];
    int          gen_count = 0;
    logic [31:0] gen_last = '0;

    // Handshake bookkeeping and idling controls.
    logic word_taken = 1'b0;
    int   words_sent = 0;
    int   results_seen = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_request = 1'b0;
    int   hold_left = 0;
    bit   hold_used = 1'b0;
    int   longest_in_stall = 0;
    int   in_stall_run = 0;

    // Coverage tallies and the failure count.
    int appends_stored = 0;
    int appends_refused = 0;
    int query_hits = 0;
    int query_misses = 0;
    int read_hits = 0;
    int read_misses = 0;
    int mismatches = 0;

    // Field-by-field comparison of one result word.
    string            field_names[10] = '{"accepted", "found", "out_time", "out_x", "out_y",
                                          "out_z", "out_pitch", "out_roll", "out_yaw",
                                          "remaining"};
    logic [31:0]      seen_fields[10];
    logic [31:0]      want_fields[10];
    waypoint_result_t due_result;

    time_ordered_waypoint_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .time_stamp(time_stamp),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .pitch_in(pitch_in),
        .roll_in(roll_in),
        .yaw_in(yaw_in),
        .entry_index(entry_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .accepted(accepted),
        .found(found),
        .out_time(out_time),
        .out_x(out_x),
        .out_y(out_y),
        .out_z(out_z),
        .out_pitch(out_pitch),
        .out_roll(out_roll),
        .out_yaw(out_yaw),
        .remaining(remaining)
    );

    // Free-running clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Prints one mismatch line, up to a cap, and counts every one.
    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    // Applies one accepted word to the shadow table and returns the result it should give.
    function automatic waypoint_result_t apply_waypoint_word(waypoint_word_t w);
        waypoint_result_t r;
        int k;
        r.accepted = 1'b0;
        r.found = 1'b0;
        r.entry = '0;
        r.remaining = REM_W'(stored_count);
        case (w.op)
            OP_APPEND:
            begin
                if (stored_count < TABLE_DEPTH &&
                    (stored_count == 0 || stored_entries[stored_count - 1].tstamp <= w.tstamp))
                begin
                    stored_entries[stored_count] = '{w.tstamp, w.x, w.y, w.z,
                                                     w.pitch, w.roll, w.yaw};
                    stored_count++;
                    r.accepted = 1'b1;
                    appends_stored++;
                end
                else
                begin
                    appends_refused++;
                end
                r.remaining = REM_W'(stored_count);
            end
            OP_QUERY:
            begin
                // The first entry strictly later than the given time wins.
                k = 0;
                while (k < stored_count && stored_entries[k].tstamp <= w.tstamp)
                begin
                    k++;
                end
                if (k < stored_count)
                begin
                    r.found = 1'b1;
                    r.entry = stored_entries[k];
                    r.remaining = REM_W'(stored_count - k);
                    query_hits++;
                end
                else
                begin
                    r.remaining = '0;
                    query_misses++;
                end
            end
            OP_READ:
            begin
                if (int'(w.idx) < stored_count)
                begin
                    r.found = 1'b1;
                    r.entry = stored_entries[w.idx];
                    read_hits++;
                end
                else
                begin
                    read_misses++;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Payload value for a position or angle, weighted towards the extremes.
    function automatic logic [31:0] pick_data();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Next arrival time that keeps the table in order; the last slot gets the top time.
    function automatic logic [31:0] next_time();
        if (gen_count == TABLE_DEPTH - 1)
        begin
            return 32'hFFFF_FFFF;
        end
        case ($urandom_range(3))
            0: return gen_last;
            1: return gen_last + 32'd1;
            default: return gen_last + $urandom_range(1000000, 1);
        endcase
    endfunction

    // Queues one word and tracks which appends the table will keep.
    task automatic queue_word(op_t wop, logic [31:0] t, logic [IDX_W-1:0] idx,
                              bit rand_data, logic [31:0] fill);
        waypoint_word_t w;
        w.op = wop;
        w.tstamp = t;
        w.idx = idx;
        w.x = rand_data ? pick_data() : fill;
        w.y = rand_data ? pick_data() : fill;
        w.z = rand_data ? pick_data() : fill;
        w.pitch = rand_data ? pick_data() : fill;
        w.roll = rand_data ? pick_data() : fill;
        w.yaw = rand_data ? pick_data() : fill;
        if (wop == OP_APPEND && gen_count < TABLE_DEPTH && (gen_count == 0 || t >= gen_last))
        begin
            gen_times[gen_count] = t;
            gen_count++;
            gen_last = t;
        end
        pending_words = {pending_words, w};
    endtask

    // Driver: offers the next word once the previous one has been taken.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || word_taken)
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                op <= pending_words[0].op;
                time_stamp <= pending_words[0].tstamp;
                pos_x <= pending_words[0].x;
                pos_y <= pending_words[0].y;
                pos_z <= pending_words[0].z;
                pitch_in <= pending_words[0].pitch;
                roll_in <= pending_words[0].roll;
                yaw_in <= pending_words[0].yaw;
                entry_index <= pending_words[0].idx;
                in_valid <= 1'b1;
                void'(pending_words.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_request && !hold_used)
            begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Monitor: predicts on each accepted word and checks each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_taken <= 1'b0;
        end
        else
        begin
            word_taken <= in_valid && !in_stall;
            in_stall_run = in_stall ? in_stall_run + 1 : 0;
            if (in_stall_run > longest_in_stall)
            begin
                longest_in_stall = in_stall_run;
            end

            if (in_valid && !in_stall)
            begin
                expected_results = {expected_results, apply_waypoint_word('{op_t'(op),
                    time_stamp, pos_x, pos_y, pos_z, pitch_in, roll_in, yaw_in,
                    entry_index})};
                words_sent++;
            end

            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end
                else
                begin
                    due_result = expected_results.pop_front();
                    seen_fields = '{{31'b0, accepted}, {31'b0, found}, out_time, out_x,
                                    out_y, out_z, out_pitch, out_roll, out_yaw,
                                    {25'b0, remaining}};
                    want_fields = '{{31'b0, due_result.accepted}, {31'b0, due_result.found},
                                    due_result.entry.tstamp, due_result.entry.x,
                                    due_result.entry.y, due_result.entry.z,
                                    due_result.entry.pitch, due_result.entry.roll,
                                    due_result.entry.yaw, {25'b0, due_result.remaining}};
                    for (int i = 0; i < 10; i++)
                    begin
                        if (seen_fields[i] !== want_fields[i])
                        begin
                            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                results_seen, field_names[i], seen_fields[i], want_fields[i]));
                        end
                    end
                end
            end
        end
    end

    // Stimulus, idling phases and the end of the run.
    initial
    begin
        int          total_words;
        int          roll_op;
        logic [31:0] t;
        logic [31:0] base;

        // Directed words: empty table, equal and earlier times, query boundaries.
        queue_word(OP_QUERY, 32'd0, '0, 1'b1, '0);
        queue_word(OP_READ, 32'd0, 6'd0, 1'b1, '0);
        queue_word(OP_NONE, 32'hFFFF_FFFF, 6'd63, 1'b0, 32'hFFFF_FFFF);
        queue_word(OP_APPEND, 32'd100, 6'd0, 1'b0, 32'h8000_0000);
        queue_word(OP_APPEND, 32'd100, 6'd63, 1'b0, 32'h7FFF_FFFF);
        queue_word(OP_APPEND, 32'd99, 6'd0, 1'b1, '0);
        queue_word(OP_APPEND, 32'd250, 6'd0, 1'b0, 32'h0000_0000);
        queue_word(OP_APPEND, 32'd250, 6'd0, 1'b0, 32'hFFFF_FFFF);
        queue_word(OP_QUERY, 32'd0, '0, 1'b1, '0);
        queue_word(OP_QUERY, 32'd99, '0, 1'b1, '0);
        queue_word(OP_QUERY, 32'd100, '0, 1'b1, '0);
        queue_word(OP_QUERY, 32'd249, '0, 1'b1, '0);
        queue_word(OP_QUERY, 32'd250, '0, 1'b1, '0);
        queue_word(OP_QUERY, 32'hFFFF_FFFF, '0, 1'b1, '0);
        queue_word(OP_READ, 32'd0, 6'd0, 1'b1, '0);
        queue_word(OP_READ, 32'd0, 6'd1, 1'b1, '0);
        queue_word(OP_READ, 32'd0, 6'd3, 1'b1, '0);
        queue_word(OP_READ, 32'd0, 6'd4, 1'b1, '0);
        queue_word(OP_READ, 32'hFFFF_FFFF, 6'd63, 1'b1, '0);
        queue_word(OP_NONE, $urandom, 6'($urandom), 1'b1, '0);
        queue_word(OP_APPEND, 32'd0, 6'd0, 1'b1, '0);

        // Random words: appends mostly with earlier times, queries near stored times, reads in range.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            roll_op = $urandom_range(99);
            if (roll_op < 30)
            begin
                if (gen_count == TABLE_DEPTH)
                begin
                    t = $urandom_range(1) ? gen_last : $urandom;
                end
                else if ($urandom_range(99) < 22 || gen_last == 0)
                begin
                    t = next_time();
                end
                else
                begin
                    t = $urandom_range(gen_last - 1, 0);
                end
                queue_word(OP_APPEND, t, 6'($urandom), 1'b1, '0);
            end
            else if (roll_op < 70)
            begin
                if (gen_count > 0 && $urandom_range(99) < 75)
                begin
                    base = gen_times[$urandom_range(gen_count - 1, 0)];
                    t = base + 32'($urandom_range(2)) - 32'd1;
                end
                else
                begin
                    case ($urandom_range(3))
                        0: t = 32'd0;
                        1: t = 32'hFFFF_FFFF;
                        default: t = $urandom;
                    endcase
                end
                queue_word(OP_QUERY, t, 6'($urandom), 1'b1, '0);
            end
            else if (roll_op < 95)
            begin
                if (gen_count > 0 && $urandom_range(99) < 80)
                begin
                    queue_word(OP_READ, $urandom, 6'($urandom_range(gen_count - 1, 0)),
                               1'b1, '0);
                end
                else
                begin
                    queue_word(OP_READ, $urandom, 6'($urandom_range(63)), 1'b1, '0);
                end
            end
            else
            begin
                queue_word(OP_NONE, $urandom, 6'($urandom), 1'b1, '0);
            end
        end

        // Make sure the table fills, then exercise it while full.
        while (gen_count < TABLE_DEPTH)
        begin
            queue_word(OP_APPEND, next_time(), 6'($urandom), 1'b1, '0);
        end
        for (int n = 0; n < 20; n++)
        begin
            case (n % 4)
                0: queue_word(OP_APPEND, gen_last, 6'($urandom), 1'b1, '0);
                1: queue_word(OP_QUERY, gen_times[$urandom_range(TABLE_DEPTH - 1)],
                              6'($urandom), 1'b1, '0);
                2: queue_word(OP_READ, $urandom, 6'(TABLE_DEPTH - 1), 1'b1, '0);
                default: queue_word(OP_READ, $urandom, 6'($urandom), 1'b1, '0);
            endcase
        end
        total_words = pending_words.size();

        // Reset held from time zero, released on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Idling phases, the last one with the long receiver hold-off.
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 77;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 77;
                end
                3:
                begin
                    send_idle_pct = 10;
                    stall_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    hold_request = 1'b1;
                end
            endcase
            while (words_sent < ((p + 1) * total_words) / 5)
            begin
                @(posedge clk);
            end
        end

        // Drain, then give any stray result time to show up.
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TABLE_DEPTH + 4) @(posedge clk);

        $display("Covered %0d words and %0d results: appends %0d stored / %0d refused,",
                 words_sent, results_seen, appends_stored, appends_refused);
        $display("queries %0d hit / %0d missed, reads %0d hit / %0d missed, input held %0d cycles.",
                 query_hits, query_misses, read_hits, read_misses, longest_in_stall);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(CYCLE_LIMIT * 20);
        $display("Timed out with %0d words taken and %0d results seen.",
                 words_sent, results_seen);
        $display("status: fail");
        $finish;
    end

endmodule
